// ===== rtl/core/bracket_pair_matcher_defines.svh =====
// ----------------------------------------------------------------------------
// Bracket pair matcher assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef BRACKET_PAIR_MATCHER_DEFINES_SVH
`define BRACKET_PAIR_MATCHER_DEFINES_SVH

`ifndef ASSERT_OFF

// The property must hold at every rising clock edge outside reset.
`define BPM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// The expression must never be true outside reset.
`define BPM_NEVER(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define BPM_ASSERT(label, clk, rstn, prop, msg)

`define BPM_NEVER(label, clk, rstn, expr, msg)

`endif

`endif

// ===== rtl/core/bpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Bracket pair matcher package
// Status codes, command characters, default sizes and the queue entry flags.
// ----------------------------------------------------------------------------
package bpm_pkg;

    localparam int BPM_STACK_DEPTH = 256;
    localparam int BPM_MAX_PROGRAM = 65536;
    localparam int QUEUE_DEPTH     = 4;
    localparam int POS_W           = 16;

    // Command characters.
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;

    // ST_PAIR doubles as "no error recorded" in the error register.
    typedef enum logic [2:0] {
        ST_PAIR  = 3'd0,
        ST_OK    = 3'd1,
        ST_DEEP  = 3'd2,
        ST_CLOSE = 3'd3,
        ST_OPEN  = 3'd4,
        ST_LONG  = 3'd5
    } status_t;

    typedef struct packed {
        logic    push;
        logic    pop;
        logic    fin;
        status_t status;
    } op_flags_t;

endpackage

// ===== rtl/core/bpm_ram.sv =====
// ----------------------------------------------------------------------------
// Bracket pair matcher RAM
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module bpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/bpm_queue.sv =====
// ----------------------------------------------------------------------------
// Bracket pair matcher queue
// Small flip-flop FIFO that decouples the classifier from the stack engine.
// ----------------------------------------------------------------------------
module bpm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = data_reg[rptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_valid && out_ready;

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            data_reg[wptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/core/bpm_front.sv =====
// ----------------------------------------------------------------------------
// Bracket pair matcher front end
// Classifies characters, tracks position, nesting depth and the sticky error,
// and turns each item into a push, pop and/or final-result operation.
// ----------------------------------------------------------------------------
`include "bracket_pair_matcher_defines.svh"

module bpm_front import bpm_pkg::*; #(
    parameter int STACK_DEPTH = BPM_STACK_DEPTH,
    parameter int MAX_PROGRAM = BPM_MAX_PROGRAM
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_character,
    input  logic                           s_end_of_program,
    output logic                           q_valid,
    input  logic                           q_ready,
    output op_flags_t                      q_flags,
    output logic [POS_W-1:0]               q_pos,
    output logic [$clog2(STACK_DEPTH)-1:0] q_addr
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int PW = $clog2(MAX_PROGRAM + 1);

    logic [DW-1:0] depth_reg, depth_next;
    logic [PW-1:0] pos_reg, pos_next;
    status_t       err_reg, err_next;
    op_flags_t     op;
    logic [AW-1:0] addr;
    logic          is_cmd;
    logic          accept;
    logic [31:0]   pos_wide;

    assign accept   = s_valid && s_ready;
    assign s_ready  = q_ready;
    assign pos_wide = 32'(pos_reg);

    always_comb begin
        is_cmd     = s_character inside {CH_GT, CH_LT, CH_PLUS, CH_MINUS,
                                         CH_DOT, CH_COMMA, CH_OPEN, CH_CLOSE};
        depth_next = depth_reg;
        pos_next   = pos_reg;
        err_next   = err_reg;
        op         = '0;
        addr       = '0;
        if (err_reg == ST_PAIR && is_cmd) begin
            if (pos_reg == PW'(MAX_PROGRAM)) begin
                err_next = ST_LONG;
            end else begin
                pos_next = pos_reg + 1'b1;
                if (s_character == CH_OPEN) begin
                    op.push    = 1'b1;
                    addr       = depth_reg[AW-1:0];
                    depth_next = depth_reg + 1'b1;
                    if (depth_next == DW'(STACK_DEPTH)) begin
                        err_next = ST_DEEP;
                    end
                end else if (s_character == CH_CLOSE) begin
                    if (depth_reg == '0) begin
                        err_next = ST_CLOSE;
                    end else begin
                        op.pop     = 1'b1;
                        depth_next = depth_reg - 1'b1;
                        addr       = depth_next[AW-1:0];
                    end
                end
            end
        end
        op.fin = s_end_of_program;
        // The final status reflects the state after this character.
        if (err_next != ST_PAIR) begin
            op.status = err_next;
        end else if (depth_next != '0) begin
            op.status = ST_OPEN;
        end else begin
            op.status = ST_OK;
        end
    end

    assign q_valid = s_valid && (op.push || op.pop || op.fin);
    assign q_flags = op;
    assign q_pos   = pos_wide[POS_W-1:0];
    assign q_addr  = addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= '0;
            pos_reg   <= '0;
            err_reg   <= ST_PAIR;
        end else if (accept) begin
            if (s_end_of_program) begin
                depth_reg <= '0;
                pos_reg   <= '0;
                err_reg   <= ST_PAIR;
            end else begin
                depth_reg <= depth_next;
                pos_reg   <= pos_next;
                err_reg   <= err_next;
            end
        end
    end

    `BPM_ASSERT(a_depth_range, aclk, aresetn, depth_reg <= DW'(STACK_DEPTH), "depth overflow")
    `BPM_ASSERT(a_last_clears, aclk, aresetn, accept && s_end_of_program |=> depth_reg == '0 && pos_reg == '0 && err_reg == ST_PAIR, "program state not cleared")
    `BPM_ASSERT(a_err_sticky, aclk, aresetn, err_reg != ST_PAIR && !(accept && s_end_of_program) |=> $stable(pos_reg) && $stable(depth_reg) && $stable(err_reg), "state moved under error")

endmodule

// ===== rtl/core/bpm_back.sv =====
// ----------------------------------------------------------------------------
// Bracket pair matcher back end
// Executes stack operations on the RAM and delivers pair and final results.
// ----------------------------------------------------------------------------
`include "bracket_pair_matcher_defines.svh"

module bpm_back import bpm_pkg::*; #(
    parameter int STACK_DEPTH = BPM_STACK_DEPTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  op_flags_t                      q_flags,
    input  logic [POS_W-1:0]               q_pos,
    input  logic [$clog2(STACK_DEPTH)-1:0] q_addr,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [15:0]                    m_open_position,
    output logic [15:0]                    m_close_position,
    output logic [2:0]                     m_status,
    output logic                           m_final_res
);

    logic             pair_reg, pair_next;
    logic             fin_reg, fin_next;
    logic [POS_W-1:0] close_reg, close_next;
    status_t          status_reg, status_next;
    logic [POS_W-1:0] rd_data;
    logic             needs_out;
    logic             take;
    logic             drain;
    logic             out_free;
    logic             op_take;

    // Pushes without the final flag never touch the output stage, so they proceed while a result waits.
    assign needs_out = q_flags.pop || q_flags.fin;
    assign take      = m_valid && m_ready;
    assign drain     = take && !(pair_reg && fin_reg);
    assign out_free  = !m_valid || drain;
    assign q_ready   = !needs_out || out_free;
    assign op_take   = q_valid && q_ready;

    bpm_ram #(
        .WIDTH (POS_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .wr_en   (op_take && q_flags.push),
        .wr_addr (q_addr),
        .wr_data (q_pos),
        .rd_en   (op_take && q_flags.pop),
        .rd_addr (q_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        pair_next   = pair_reg;
        fin_next    = fin_reg;
        close_next  = close_reg;
        status_next = status_reg;
        if (take) begin
            if (pair_reg) begin
                pair_next = 1'b0;
            end else begin
                fin_next = 1'b0;
            end
        end
        if (op_take && needs_out) begin
            pair_next   = q_flags.pop;
            fin_next    = q_flags.fin;
            close_next  = q_pos;
            status_next = q_flags.status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end else begin
            pair_reg <= pair_next;
            fin_reg  <= fin_next;
        end
    end

    always_ff @(posedge aclk) begin
        close_reg  <= close_next;
        status_reg <= status_next;
    end

    // A pair goes out before the final result of the same character.
    assign m_valid          = pair_reg || fin_reg;
    assign m_open_position  = pair_reg ? rd_data : '0;
    assign m_close_position = pair_reg ? close_reg : '0;
    assign m_status         = pair_reg ? ST_PAIR : status_reg;
    assign m_final_res      = !pair_reg;

    `BPM_NEVER(a_push_pop, aclk, aresetn, q_valid && q_flags.push && q_flags.pop, "push and pop in one operation")
    `BPM_ASSERT(a_pop_loads, aclk, aresetn, op_take && q_flags.pop |=> pair_reg, "pop did not load a pair")
    `BPM_ASSERT(a_pair_then_fin, aclk, aresetn, pair_reg && fin_reg && take |=> fin_reg && !pair_reg, "final result lost after pair")

endmodule

// ===== rtl/core/bracket_pair_matcher.sv =====
// ----------------------------------------------------------------------------
// Bracket pair matcher
// Stack-based bracket matching over a program streamed one byte per item.
// ----------------------------------------------------------------------------
// The block accepts one character per clock cycle while its queue has room.
// Only the eight command characters take positions; each matched pair of
// brackets produces a pair result, and the character flagged as end of
// program also produces a final result with the program status (a sticky
// error, an unmatched open bracket, or ok). A character that yields both a
// pair and a final result sends them on the result port one after the
// other; a short queue between the classifier and the stack engine absorbs
// that. The opening positions live in a RAM of STACK_DEPTH entries with a
// registered read. Each result is registered first in the queue and then in
// the output register, which loads together with the RAM read. No clearing
// pass is needed after reset, since a pop only reads entries pushed earlier
// in the same program.
module bracket_pair_matcher import bpm_pkg::*; #(
    parameter int STACK_DEPTH = BPM_STACK_DEPTH,
    parameter int MAX_PROGRAM = BPM_MAX_PROGRAM
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_character,
    input  logic        s_end_of_program,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_open_position,
    output logic [15:0] m_close_position,
    output logic [2:0]  m_status,
    output logic        m_final_res
);

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int OP_W = $bits(op_flags_t) + POS_W + AW;

    logic             f_valid, f_ready;
    op_flags_t        f_flags;
    logic [POS_W-1:0] f_pos;
    logic [AW-1:0]    f_addr;
    logic [OP_W-1:0]  f_data;

    logic             b_valid, b_ready;
    op_flags_t        b_flags;
    logic [POS_W-1:0] b_pos;
    logic [AW-1:0]    b_addr;
    logic [OP_W-1:0]  b_data;

    bpm_front #(
        .STACK_DEPTH (STACK_DEPTH),
        .MAX_PROGRAM (MAX_PROGRAM)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_character      (s_character),
        .s_end_of_program (s_end_of_program),
        .q_valid          (f_valid),
        .q_ready          (f_ready),
        .q_flags          (f_flags),
        .q_pos            (f_pos),
        .q_addr           (f_addr)
    );

    assign f_data = {f_flags, f_pos, f_addr};

    bpm_queue #(
        .WIDTH (OP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    assign {b_flags, b_pos, b_addr} = b_data;

    bpm_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (b_valid),
        .q_ready          (b_ready),
        .q_flags          (b_flags),
        .q_pos            (b_pos),
        .q_addr           (b_addr),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_open_position  (m_open_position),
        .m_close_position (m_close_position),
        .m_status         (m_status),
        .m_final_res      (m_final_res)
    );

endmodule
